// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the lru page replacement top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lrupr_pkg.sv -----
// types and constants for the lru page replacement block
package lrupr_pkg;

  localparam int unsigned PAGE_W          = 16;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned CFG_W           = 5;
  localparam int unsigned IDX_W           = 6;
  localparam int unsigned LRUPR_MAX_FRAMES = 16;
  localparam int unsigned LRUPR_PAGE_BITS  = 16;
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(3);

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;
  } ref_item_t;

  typedef struct packed {
    logic               fault;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
    logic               string_done;
  } res_item_t;

  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  upto;
    logic [PAGE_W-1:0] page;
  } chain_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_at;
    logic [PAGE_W-1:0] tail_page;
  } chain_sts_t;

endpackage

// ----- hw/rtl/lrupr_cell.sv -----
// one recency stack slot: page, valid bit and tag compare
module lrupr_cell #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic [W-1:0] d_page,
  input  logic         d_valid,
  input  logic [W-1:0] cmp_page,
  output logic [W-1:0] page,
  output logic         valid,
  output logic         match
);

  always_ff @(posedge clk) begin
    if (shift) begin
      page <= d_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d_valid;
    end
  end

  assign match = valid && (page == cmp_page);

endmodule

// ----- hw/rtl/lrupr_chain.sv -----
// row of recency cells, hit encoder and tail page select
module lrupr_chain #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrupr_pkg::chain_ctl_t ctl,
  output lrupr_pkg::chain_sts_t sts
);
  import lrupr_pkg::*;

  localparam int unsigned StoreBits = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  logic [StoreBits-1:0]  page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] tail;
  logic [StoreBits-1:0]  cmp_page;
  logic [StoreBits-1:0]  tail_sel;
  logic [IDX_W-1:0]      hit_idx;

  assign cmp_page = ctl.page[StoreBits-1:0];

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [StoreBits-1:0] d_page;
    logic                 d_valid;
    logic                 shift;

    // slot 0 takes the new page, others take their upper neighbor
    if (i == 0) begin : g_head
      assign d_page  = cmp_page;
      assign d_valid = 1'b1;
    end else begin : g_body
      assign d_page  = page_q[i-1];
      assign d_valid = valid_q[i-1];
    end

    assign shift = ctl.load && (IDX_W'(i) <= ctl.upto);

    // least recent slot is the last valid one
    if (i == MAX_FRAMES - 1) begin : g_last
      assign tail[i] = valid_q[i];
    end else begin : g_mid
      assign tail[i] = valid_q[i] && !valid_q[i+1];
    end

    lrupr_cell #(.W(StoreBits)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .d_page   (d_page),
      .d_valid  (d_valid),
      .cmp_page (cmp_page),
      .page     (page_q[i]),
      .valid    (valid_q[i]),
      .match    (match[i])
    );
  end

  // resident pages are unique, so at most one match and one tail
  always_comb begin
    hit_idx  = '0;
    tail_sel = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (tail[i]) begin
        tail_sel = tail_sel | page_q[i];
      end
    end
  end

  assign sts.hit       = |match;
  assign sts.hit_at    = hit_idx;
  assign sts.tail_page = PAGE_W'(tail_sel);

endmodule

// ----- hw/rtl/lru_page_replacement_top.sv -----
// top level of the fully associative lru page replacement block
//
//  channel | signals                    | transfer when
//  --------+----------------------------+------------------------
//  ref     | ref_valid ref_stall ref_item | ref_valid && !ref_stall
//  res     | res_valid res_stall res_item | res_valid && !res_stall
//  cfg     | cfg_valid cfg_ready cfg_data | cfg_valid && cfg_ready
//
// one page reference per cycle while ref_stall is low; its result appears in the
// output register the cycle after the transfer. the whole compare, encode and
// stack shift across the cell row completes in the same cycle as the transfer.
// rst (synchronous) empties the stack, clears the fault count and sets the
// frame limit to 3. ref_stall is high only while a result waits in the
// output register and res_stall holds it there.
`include "assert_macros.svh"

module lru_page_replacement_top #(
  parameter int unsigned MAX_FRAMES = lrupr_pkg::LRUPR_MAX_FRAMES,
  parameter int unsigned PAGE_BITS  = lrupr_pkg::LRUPR_PAGE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ref_valid,
  output logic                          ref_stall,
  input  lrupr_pkg::ref_item_t          ref_item,
  output logic                          res_valid,
  input  logic                          res_stall,
  output lrupr_pkg::res_item_t          res_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_data
);
  import lrupr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CmpW = (CntW > CFG_W) ? CntW : CFG_W;

  logic [CFG_W-1:0]   frames_in_use;
  logic [CntW-1:0]    occ;
  logic [CntW-1:0]    occ_next;
  logic [COUNT_W-1:0] running;
  logic [COUNT_W-1:0] running_next;
  logic [COUNT_W-1:0] count_out;
  logic [CmpW-1:0]    cfg_ext;
  logic [CmpW-1:0]    lim;
  logic               room;
  logic               accept;
  logic               evict;
  chain_ctl_t         ctl;
  chain_sts_t         sts;
  res_item_t          res_next;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  // clamp the limit to 1..MAX_FRAMES
  assign cfg_ext = CmpW'(frames_in_use);

  always_comb begin
    priority if (cfg_ext == '0) begin
      lim = CmpW'(1);
    end else if (cfg_ext > CmpW'(MAX_FRAMES)) begin
      lim = CmpW'(MAX_FRAMES);
    end else begin
      lim = cfg_ext;
    end
  end

  // input side stalls only while a finished result is held
  assign ref_stall = res_valid && res_stall;
  assign accept    = ref_valid && !ref_stall;

  assign room  = CmpW'(occ) < lim;
  assign evict = !sts.hit && !room;

  // shift depth: hit slot, fill point, or overwrite of the lru slot
  always_comb begin
    ctl.load = accept;
    ctl.page = ref_item.page_number;
    priority if (sts.hit) begin
      ctl.upto = sts.hit_at;
    end else if (room) begin
      ctl.upto = IDX_W'(occ);
    end else begin
      ctl.upto = IDX_W'(occ - CntW'(1));
    end
  end

  assign occ_next = (!sts.hit && room) ? occ + CntW'(1) : occ;

  // saturating fault count, cleared after the last reference of a string
  always_comb begin
    count_out = running;
    if (!sts.hit && (running != '1)) begin
      count_out = running + COUNT_W'(1);
    end
    running_next = ref_item.last_reference ? '0 : count_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= '0;
      running <= '0;
    end else if (accept) begin
      occ     <= occ_next;
      running <= running_next;
    end
  end

  lrupr_chain #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_chain (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts)
  );

  // result assembly
  always_comb begin
    res_next.fault         = !sts.hit;
    res_next.evicted_valid = evict;
    res_next.evicted_page  = evict ? sts.tail_page : '0;
    res_next.fault_count   = count_out;
    res_next.string_done   = ref_item.last_reference;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_item <= res_next;
    end
  end

  `ASSERT_CLK(a_occ_bound, (32'(occ) <= MAX_FRAMES), "occupancy above frame count")
  `ASSERT_CLK(a_evict_is_fault, (res_valid |-> (!res_item.evicted_valid || res_item.fault)), "eviction without fault")
  `ASSERT_CLK(a_fill_grows, ((accept && !sts.hit && room) |=> (occ == $past(occ) + CntW'(1))), "free frame not filled")
  `ASSERT_CLK(a_last_clears, ((accept && ref_item.last_reference) |=> (running == '0)), "fault count kept after last reference")

endmodule

// ----- tb/lru_page_replacement_top_test.sv -----
// self-checking testbench for the lru page replacement top level
module lru_page_replacement_top_test;
  import lrupr_pkg::*;

  // cycles with no transfer on any channel before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // length of the long receiver hold-off, in cycles
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned PHASE_ITEMS = 230;
  localparam int unsigned POOL_SIZE = 32;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             ref_valid = 1'b0;
  logic             ref_stall;
  ref_item_t        ref_item = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_item_t        res_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  lru_page_replacement_top dut (
    .clk       (clk),
    .rst       (rst),
    .ref_valid (ref_valid),
    .ref_stall (ref_stall),
    .ref_item  (ref_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state: recency stack, slot 0 is most recent
  logic [PAGE_W-1:0]  stack_page [LRUPR_MAX_FRAMES];
  logic               stack_live [LRUPR_MAX_FRAMES];
  int unsigned        resident;
  logic [COUNT_W-1:0] string_faults;
  logic [CFG_W-1:0]   frames_reg;

  // outcomes predicted at each reference transfer, oldest first
  res_item_t   predicted_outcomes [$];
  int unsigned mismatches = 0;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // bumped by a test to ask the receiver for one long hold-off
  int unsigned hold_requests = 0;

  // pages the random traffic mostly draws from, so hits are common
  logic [PAGE_W-1:0] working_set [POOL_SIZE];

  // effective limit: zero behaves as one, anything past the stack as full
  function automatic int unsigned frame_limit();
    int unsigned lim;
    lim = 32'(frames_reg);
    if (lim < 1) lim = 1;
    if (lim > LRUPR_MAX_FRAMES) lim = LRUPR_MAX_FRAMES;
    return lim;
  endfunction

  // shift slots below upto down by one and put page on top
  function automatic void move_to_front(int unsigned upto, logic [PAGE_W-1:0] page);
    for (int i = int'(upto); i > 0; i--) begin
      stack_page[i] = stack_page[i-1];
      stack_live[i] = stack_live[i-1];
    end
    stack_page[0] = page;
    stack_live[0] = 1'b1;
  endfunction

  // one page reference through the lru policy, returns the outcome
  function automatic res_item_t lru_access(ref_item_t it);
    res_item_t         r;
    logic [PAGE_W-1:0] page;
    logic              hit;
    int unsigned       hit_at;
    r = '0;
    page = it.page_number;
    hit = 1'b0;
    hit_at = 0;
    for (int unsigned i = 0; i < resident; i++) begin
      if (!hit && stack_live[i] && stack_page[i] == page) begin
        hit = 1'b1;
        hit_at = i;
      end
    end
    if (hit) begin
      move_to_front(hit_at, page);
    end else begin
      if (resident < frame_limit()) begin
        move_to_front(resident, page);
        resident++;
      end else begin
        // a lowered limit still evicts just the one least recent page
        r.evicted_valid = 1'b1;
        r.evicted_page = stack_page[resident-1];
        move_to_front(resident - 1, page);
      end
      if (string_faults != '1) string_faults++;
    end
    r.fault = !hit;
    r.fault_count = string_faults;
    r.string_done = it.last_reference;
    if (it.last_reference) string_faults = '0;
    return r;
  endfunction

  // offer one reference with random leading gaps, predict on transfer
  task automatic send_reference(logic [PAGE_W-1:0] page, logic last);
    ref_item_t it;
    res_item_t outcome;
    it.page_number = page;
    it.last_reference = last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      ref_valid = 1'b0;
      @(negedge clk);
    end
    ref_valid = 1'b1;
    ref_item = it;
    do @(posedge clk); while (ref_stall);
    outcome = lru_access(it);
    predicted_outcomes = {predicted_outcomes, outcome};
  endtask

  task automatic release_references();
    @(negedge clk);
    ref_valid = 1'b0;
  endtask

  // stop offering and let every predicted outcome come back
  task automatic wait_for_results();
    release_references();
    while (predicted_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // frame limit is only changed with the block idle
  task automatic write_frames(logic [CFG_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    frames_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic refill_working_set();
    for (int i = 0; i < POOL_SIZE; i++) working_set[i] = PAGE_W'($urandom_range(16'hFFFF));
  endtask

  // mostly pages from a set a little larger than the limit, some fresh ones
  task automatic send_random_reference();
    int unsigned       span;
    logic [PAGE_W-1:0] page;
    span = frame_limit() + 4;
    if (span > POOL_SIZE) span = POOL_SIZE;
    if ($urandom_range(99) < 85) page = working_set[$urandom_range(span - 1)];
    else page = PAGE_W'($urandom_range(16'hFFFF));
    send_reference(page, $urandom_range(24) == 0);
  endtask

  // reset limit of three: fill, hit at every depth, evict, end of string
  task automatic test_hit_miss_evict();
    send_reference(16'h0000, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'h0000, 1'b0);
    send_reference(16'h5A5A, 1'b0);
    // stack full, least recent is ffff
    send_reference(16'hA5A5, 1'b0);
    // two hits in a row on the least recent slot
    send_reference(16'h0000, 1'b0);
    send_reference(16'h5A5A, 1'b0);
    // miss that evicts and closes the string, count clears after it
    send_reference(16'hFFFF, 1'b1);
    send_reference(16'hFFFF, 1'b0);
  endtask

  // oversized limit, limit lowered under occupancy, limit of zero
  task automatic test_frame_limit_extremes();
    write_frames(CFG_W'(31));
    // fills all sixteen frames, the last one evicts
    for (int i = 0; i < 14; i++) send_reference(PAGE_W'(16'h1000 + i), 1'b0);
    write_frames(CFG_W'(2));
    // deep page still hits, a miss evicts one and occupancy stays put
    send_reference(16'h1000, 1'b0);
    send_reference(16'h2000, 1'b0);
    write_frames(CFG_W'(0));
    send_reference(16'h2000, 1'b0);
    send_reference(16'h8001, 1'b1);
  endtask

  task automatic test_random_traffic(logic [CFG_W-1:0] frames, int unsigned items);
    write_frames(frames);
    refill_working_set();
    repeat (items) send_random_reference();
  endtask

  // receiver holds off long while references keep coming, input backs up
  task automatic test_output_hold_off();
    hold_requests++;
    repeat (40) send_random_reference();
  endtask

  // sender goes quiet until the block has returned everything
  task automatic test_sender_pause();
    repeat (20) send_random_reference();
    wait_for_results();
    repeat (20) send_random_reference();
  endtask

  // receiver side: random stall, or a counted hold-off when asked
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      res_stall = 1'b1;
      hold_left--;
    end else begin
      res_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void compare_field(string field, logic [COUNT_W-1:0] want,
                                        logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // check every result transfer against the oldest prediction
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (predicted_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, res_item);
        mismatches++;
      end else begin
        want = predicted_outcomes.pop_front();
        compare_field("fault", COUNT_W'(want.fault), COUNT_W'(res_item.fault));
        compare_field("evicted_valid", COUNT_W'(want.evicted_valid),
                      COUNT_W'(res_item.evicted_valid));
        compare_field("evicted_page", COUNT_W'(want.evicted_page),
                      COUNT_W'(res_item.evicted_page));
        compare_field("fault_count", want.fault_count, res_item.fault_count);
        compare_field("string_done", COUNT_W'(want.string_done),
                      COUNT_W'(res_item.string_done));
      end
    end
  end

  // hang detection: any transfer restarts the count
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (ref_valid && !ref_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned drain;
    // predictor matches the block after reset
    for (int i = 0; i < LRUPR_MAX_FRAMES; i++) begin
      stack_page[i] = '0;
      stack_live[i] = 1'b0;
    end
    resident = 0;
    string_faults = '0;
    frames_reg = FRAMES_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part with no idling
    test_hit_miss_evict();
    test_frame_limit_extremes();

    // sender sparse gaps, receiver mostly stalled
    send_idle_pct = 19;
    recv_stall_pct = 76;
    test_random_traffic(CFG_W'(16), PHASE_ITEMS);
    test_random_traffic(CFG_W'(1), PHASE_ITEMS);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 76;
    recv_stall_pct = 19;
    test_random_traffic(CFG_W'(31), PHASE_ITEMS);
    test_random_traffic(CFG_W'(4), PHASE_ITEMS);

    // back to back, then the pressure cases
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(CFG_W'(0), PHASE_ITEMS);
    test_random_traffic(CFG_W'($urandom_range(2, 15)), PHASE_ITEMS);
    test_random_traffic(CFG_W'(8), PHASE_ITEMS);
    test_output_hold_off();
    test_sender_pause();

    // drain with a bound, then wait on for anything stray
    release_references();
    for (drain = 0; drain < WATCHDOG_LIMIT && predicted_outcomes.size() != 0; drain++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (predicted_outcomes.size() != 0) begin
      $display("%0t: expected %0d more results, actual none", $time,
               predicted_outcomes.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
